@@ hw/rtl/sbh_pkg.sv @@
package sbh_pkg;

    // Request kinds carried on the input tuser
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Transaction phases
    localparam logic [1:0] PH_IDLE       = 2'd0;
    localparam logic [1:0] PH_WAIT_FIRST = 2'd1;
    localparam logic [1:0] PH_WAIT_REPLY = 2'd2;

    // Reply shapes
    localparam logic [1:0] RK_ACK_ONLY = 2'd0;
    localparam logic [1:0] RK_ONE_BYTE = 2'd1;

    // Result kinds and completion codes
    localparam logic       KIND_TX   = 1'b0;
    localparam logic       KIND_DONE = 1'b1;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_NACK    = 2'd2;

    localparam logic [7:0]  ACK_BYTE      = 8'h79;
    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

    // Register offsets (word index taken from paddr[2])
    localparam logic REG_TIMEOUT = 1'b0;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  cmd_code;
        logic        send_complement;
        logic [2:0]  arg_count;
        logic [31:0] arg_word;
        logic        add_checksum;
        logic [1:0]  reply_kind;
        logic [7:0]  rx_data;
    } item_t;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  tx_data;
        logic [1:0]  status;
        logic [31:0] reply_data;
    } res_t;

    function automatic res_t mk_tx(input logic [7:0] b);
        res_t r;
        r.out_kind   = KIND_TX;
        r.tx_data    = b;
        r.status     = ST_OK;
        r.reply_data = 32'd0;
        return r;
    endfunction

    function automatic res_t mk_done(input logic [1:0] st, input logic [31:0] d);
        res_t r;
        r.out_kind   = KIND_DONE;
        r.tx_data    = 8'd0;
        r.status     = st;
        r.reply_data = d;
        return r;
    endfunction

endpackage

@@ hw/rtl/serial_bootloader_host_transaction.sv @@
// Path: an accepted input word is registered in the input holding register, and its
// result words are registered in the output batch register; later words follow one per
// cycle while m_tready is high. Throughput: one input word per cycle while the batch
// register is free; a batch holds it until its last word is taken, when the next can load.
// Items that yield no result pass at one per cycle regardless of the output side.
// Reset: asynchronous, active low; phase idle, all counters zero, timeout 5000 ticks.
module serial_bootloader_host_transaction #(
    parameter int MAX_ARG_BYTES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd_code[7:0], send_complement[8], arg_count[11:9], arg_word[43:12],
    // add_checksum[44], reply_kind[46:45], rx_data[54:47], zero pad[55]
    input  logic [55:0] s_tdata,
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // tx_data[7:0], status[9:8], reply_data[41:10]
    output logic        m_tuser,   // out_kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NB = MAX_ARG_BYTES + 1;
    localparam int CW = $clog2(NB + 1);

    logic [15:0]    timeout_reg;
    logic           in_valid_reg;
    logic [55:0]    in_data_reg;
    logic [1:0]     in_user_reg;
    sbh_pkg::item_t item;
    sbh_pkg::res_t  res [NB];
    logic [CW-1:0]  res_count;
    logic           free;
    logic           fire;
    logic           in_hs;

    // Register access
    assign pready = 1'b1;
    assign prdata = (paddr[2] == sbh_pkg::REG_TIMEOUT) ? {16'd0, timeout_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= sbh_pkg::TIMEOUT_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == sbh_pkg::REG_TIMEOUT)
            timeout_reg <= pwdata[15:0];
    end

    // Unpack the held input word
    assign item.req_type        = in_user_reg;
    assign item.cmd_code        = in_data_reg[7:0];
    assign item.send_complement = in_data_reg[8];
    assign item.arg_count       = in_data_reg[11:9];
    assign item.arg_word        = in_data_reg[43:12];
    assign item.add_checksum    = in_data_reg[44];
    assign item.reply_kind      = in_data_reg[46:45];
    assign item.rx_data         = in_data_reg[54:47];

    // Retire the held word when its results fit or it has none
    assign fire     = in_valid_reg && (free || res_count == '0);
    assign s_tready = !in_valid_reg || fire;
    assign in_hs    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_hs || (in_valid_reg && !fire);
    end

    always_ff @(posedge clk)
    begin
        if (in_hs)
        begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
    end

    sbh_ctrl #(
        .MAX_ARG_BYTES (MAX_ARG_BYTES),
        .NB            (NB),
        .CW            (CW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .item          (item),
        .timeout_ticks (timeout_reg),
        .res           (res),
        .res_count     (res_count)
    );

    sbh_batch #(
        .NB (NB),
        .CW (CW)
    ) u_batch (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && res_count != '0),
        .res       (res),
        .res_count (res_count),
        .free      (free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

@@ hw/rtl/sbh_ctrl.sv @@
module sbh_ctrl #(
    parameter int MAX_ARG_BYTES = 4,
    parameter int NB = MAX_ARG_BYTES + 1,
    parameter int CW = $clog2(NB + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  sbh_pkg::item_t      item,
    input  logic [15:0]         timeout_ticks,
    output sbh_pkg::res_t       res [NB],
    output logic [CW-1:0]       res_count
);

    logic [1:0]  phase_reg, phase_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [2:0]  rindex_reg, rindex_next;
    logic [31:0] rshift_reg, rshift_next;
    logic [31:0] hword_reg, hword_next;
    logic [2:0]  hcount_reg, hcount_next;
    logic        hcsum_reg, hcsum_next;
    logic [1:0]  hkind_reg, hkind_next;

    logic [2:0]  cnt_sat;
    logic [2:0]  ndata;
    logic [7:0]  xsum;
    logic [7:0]  abyte [MAX_ARG_BYTES];
    logic [2:0]  sh    [MAX_ARG_BYTES];

    // Clamp the argument count of a start item
    always_comb
    begin
        if ({1'b0, item.arg_count} > 4'(MAX_ARG_BYTES))
            cnt_sat = 3'(MAX_ARG_BYTES);
        else
            cnt_sat = item.arg_count;
    end

    // Pick argument bytes most significant first, and fold them into the checksum
    always_comb
    begin
        xsum = 8'd0;
        for (int i = 0; i < MAX_ARG_BYTES; i++)
        begin
            sh[i] = 3'(hcount_reg - 3'd1 - 3'(i));
            if (sh[i][2])
                abyte[i] = 8'd0;
            else
                abyte[i] = hword_reg[{sh[i][1:0], 3'b000} +: 8];
            if ({1'b0, 3'(i)} < {1'b0, hcount_reg})
                xsum = xsum ^ abyte[i];
        end
    end

    assign ndata = (hkind_reg == sbh_pkg::RK_ACK_ONLY) ? 3'd0 :
                   (hkind_reg == sbh_pkg::RK_ONE_BYTE) ? 3'd1 : 3'd4;

    // Work out the next state and the results of the held item
    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        rindex_next  = rindex_reg;
        rshift_next  = rshift_reg;
        hword_next   = hword_reg;
        hcount_next  = hcount_reg;
        hcsum_next   = hcsum_reg;
        hkind_next   = hkind_reg;
        res_count    = '0;
        for (int j = 0; j < NB; j++)
            res[j] = sbh_pkg::mk_tx(8'd0);

        case (item.req_type)
            sbh_pkg::REQ_START:
            begin
                if (phase_reg == sbh_pkg::PH_IDLE)
                begin
                    hword_next  = item.arg_word;
                    hcount_next = cnt_sat;
                    hcsum_next  = item.add_checksum;
                    hkind_next  = item.reply_kind;
                    res[0]      = sbh_pkg::mk_tx(item.cmd_code);
                    res[1]      = sbh_pkg::mk_tx(~item.cmd_code);
                    res_count   = CW'(1) + CW'(item.send_complement);
                    elapsed_next = 16'd0;
                    if (cnt_sat != 3'd0)
                        phase_next = sbh_pkg::PH_WAIT_FIRST;
                    else
                    begin
                        phase_next  = sbh_pkg::PH_WAIT_REPLY;
                        rindex_next = 3'd0;
                        rshift_next = 32'd0;
                    end
                end
            end
            sbh_pkg::REQ_TICK:
            begin
                if (phase_reg != sbh_pkg::PH_IDLE)
                begin
                    if ({1'b0, elapsed_reg} + 17'd1 > {1'b0, timeout_ticks})
                    begin
                        res[0]     = sbh_pkg::mk_done(sbh_pkg::ST_TIMEOUT, 32'd0);
                        res_count  = CW'(1);
                        phase_next = sbh_pkg::PH_IDLE;
                    end
                    else
                        elapsed_next = elapsed_reg + 16'd1;
                end
            end
            sbh_pkg::REQ_BYTE:
            begin
                if (phase_reg == sbh_pkg::PH_WAIT_FIRST)
                begin
                    if (item.rx_data != sbh_pkg::ACK_BYTE)
                    begin
                        res[0]     = sbh_pkg::mk_done(sbh_pkg::ST_NACK, 32'd0);
                        res_count  = CW'(1);
                        phase_next = sbh_pkg::PH_IDLE;
                    end
                    else
                    begin
                        for (int i = 0; i < MAX_ARG_BYTES; i++)
                            if ({1'b0, 3'(i)} < {1'b0, hcount_reg})
                                res[i] = sbh_pkg::mk_tx(abyte[i]);
                        for (int j = 0; j < NB; j++)
                            if (hcsum_reg && ({1'b0, 3'(j)} == {1'b0, hcount_reg}))
                                res[j] = sbh_pkg::mk_tx(xsum);
                        res_count    = CW'(hcount_reg) + CW'(hcsum_reg);
                        phase_next   = sbh_pkg::PH_WAIT_REPLY;
                        elapsed_next = 16'd0;
                        rindex_next  = 3'd0;
                        rshift_next  = 32'd0;
                    end
                end
                else if (phase_reg == sbh_pkg::PH_WAIT_REPLY)
                begin
                    if (rindex_reg == 3'd0)
                    begin
                        if (item.rx_data != sbh_pkg::ACK_BYTE)
                        begin
                            res[0]     = sbh_pkg::mk_done(sbh_pkg::ST_NACK, 32'd0);
                            res_count  = CW'(1);
                            phase_next = sbh_pkg::PH_IDLE;
                        end
                        else if (ndata == 3'd0)
                        begin
                            res[0]     = sbh_pkg::mk_done(sbh_pkg::ST_OK, 32'd0);
                            res_count  = CW'(1);
                            phase_next = sbh_pkg::PH_IDLE;
                        end
                        else
                            rindex_next = 3'd1;
                    end
                    else if (rindex_reg <= ndata)
                    begin
                        rshift_next = {rshift_reg[23:0], item.rx_data};
                        rindex_next = rindex_reg + 3'd1;
                    end
                    else
                    begin
                        if (item.rx_data != sbh_pkg::ACK_BYTE)
                            res[0] = sbh_pkg::mk_done(sbh_pkg::ST_NACK, 32'd0);
                        else
                            res[0] = sbh_pkg::mk_done(sbh_pkg::ST_OK, rshift_reg);
                        res_count  = CW'(1);
                        phase_next = sbh_pkg::PH_IDLE;
                    end
                end
            end
            default:
            begin
                res_count = '0;
            end
        endcase
    end

    // Advance the transaction state once the item is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= sbh_pkg::PH_IDLE;
            elapsed_reg <= 16'd0;
            rindex_reg  <= 3'd0;
            rshift_reg  <= 32'd0;
            hword_reg   <= 32'd0;
            hcount_reg  <= 3'd0;
            hcsum_reg   <= 1'b0;
            hkind_reg   <= 2'd0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            rindex_reg  <= rindex_next;
            rshift_reg  <= rshift_next;
            hword_reg   <= hword_next;
            hcount_reg  <= hcount_next;
            hcsum_reg   <= hcsum_next;
            hkind_reg   <= hkind_next;
        end
    end

    // Reply index never runs past the closing ACK of a four byte reply
    a_rindex_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == sbh_pkg::PH_WAIT_REPLY |-> rindex_reg <= 3'd5)
        else $error("reply index out of range");

    // Nothing is produced for bytes or ticks while idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == sbh_pkg::PH_IDLE && item.req_type != sbh_pkg::REQ_START)
        |-> res_count == '0)
        else $error("result produced while idle");

    // A finished transaction always returns to idle
    a_done_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_count == CW'(1) && res[0].out_kind == sbh_pkg::KIND_DONE)
        |=> phase_reg == sbh_pkg::PH_IDLE)
        else $error("finish without return to idle");

endmodule

@@ hw/rtl/sbh_batch.sv @@
module sbh_batch #(
    parameter int NB = 5,
    parameter int CW = $clog2(NB + 1),
    parameter int HW = $clog2(NB)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  sbh_pkg::res_t       res [NB],
    input  logic [CW-1:0]       res_count,
    output logic                free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [47:0]         m_tdata,  // tx_data[7:0], status[9:8], reply_data[41:10]
    output logic                m_tuser,  // out_kind
    output logic                m_tlast
);

    sbh_pkg::res_t entry_reg [NB];
    logic [CW-1:0] count_reg;
    logic [HW-1:0] head_reg;
    logic          out_hs;
    sbh_pkg::res_t cur;

    assign out_hs   = m_tvalid && m_tready;
    assign m_tvalid = count_reg != '0;
    assign free     = (count_reg == '0) || (count_reg == CW'(1) && m_tready);
    assign cur      = entry_reg[head_reg];
    assign m_tdata  = {6'd0, cur.reply_data, cur.status, cur.tx_data};
    assign m_tuser  = cur.out_kind;
    assign m_tlast  = count_reg == CW'(1);

    // Load a fresh batch or step through the held one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            head_reg  <= '0;
        end
        else if (load)
        begin
            count_reg <= res_count;
            head_reg  <= '0;
        end
        else if (out_hs)
        begin
            count_reg <= count_reg - CW'(1);
            head_reg  <= head_reg + HW'(1);
        end
    end

    // Hold the result words of the batch
    always_ff @(posedge clk)
    begin
        if (load)
            entry_reg <= res;
    end

    // A new batch never lands on words still waiting
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (count_reg == '0 || (count_reg == CW'(1) && out_hs)))
        else $error("batch overwritten");

    // Batch never holds more words than it has room for
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(NB))
        else $error("batch count out of range");

    // Each taken word retires exactly one entry
    a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_hs && !load && count_reg > CW'(1)) |=> count_reg == $past(count_reg) - CW'(1))
        else $error("batch count stepped wrongly");

endmodule

@@ sim/tb_serial_bootloader_host_transaction.sv @@
`timescale 1ns / 1ps

module tb_serial_bootloader_host_transaction;

    localparam int ARG_BYTES_MAX = 4;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [2:0] ADDR_TIMEOUT = 3'd0;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx;
        logic [1:0]  st;
        logic [31:0] data;
        logic        last;
    } out_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // cmd_code[7:0], send_complement[8], arg_count[11:9], arg_word[43:12],
    // add_checksum[44], reply_kind[46:45], rx_data[54:47], zero pad[55]
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = sbh_pkg::REQ_START;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;               // tx_data[7:0], status[9:8], reply_data[41:10]
    logic        m_tuser;               // out_kind
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Host model state
    logic [1:0]  model_phase = sbh_pkg::PH_IDLE;
    logic [15:0] wait_ticks = '0;
    logic [2:0]  reply_pos = '0;
    logic [31:0] reply_acc = '0;
    logic [31:0] held_word = '0;
    logic [2:0]  held_count = '0;
    logic        held_csum = 1'b0;
    logic [1:0]  held_kind = '0;
    logic [15:0] limit_ticks = sbh_pkg::TIMEOUT_RESET;

    sbh_pkg::item_t item_q[$];
    sbh_pkg::item_t cur_item;
    out_word_t   step_words[$];
    out_word_t   due_words[$];
    out_word_t   seen_word;
    int          items_open = 0;
    int          items_made = 0;
    int          err_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          run_left = 0;
    logic        run_ready = 1'b1;
    int          rx_stall_pct = 0;
    int          hold_left = 0;
    logic        long_hold_req = 1'b0;
    logic        long_hold_done = 1'b0;
    int          quiet_cycles = 0;

    serial_bootloader_host_transaction #(
        .MAX_ARG_BYTES(ARG_BYTES_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #5 clk = ~clk;

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    // Host transaction predictor

    task automatic push_tx(input logic [7:0] b);
        step_words.push_back({sbh_pkg::KIND_TX, b, sbh_pkg::ST_OK, 32'd0, 1'b0});
    endtask

    task automatic finish_txn(input logic [1:0] st, input logic [31:0] d);
        step_words.push_back({sbh_pkg::KIND_DONE, 8'd0, st, d, 1'b0});
        model_phase = sbh_pkg::PH_IDLE;
    endtask

    task automatic enter_reply_wait();
        model_phase = sbh_pkg::PH_WAIT_REPLY;
        wait_ticks = '0;
        reply_pos = '0;
        reply_acc = '0;
    endtask

    task automatic predict_words(input sbh_pkg::item_t it);
        int cnt;
        int sh;
        int ndata;
        logic [7:0] b;
        logic [7:0] x;
        step_words.delete();
        case (it.req_type)
            sbh_pkg::REQ_START:
            begin
                if (model_phase == sbh_pkg::PH_IDLE)
                begin
                    cnt = (it.arg_count > ARG_BYTES_MAX) ? ARG_BYTES_MAX : int'(it.arg_count);
                    held_word = it.arg_word;
                    held_count = 3'(cnt);
                    held_csum = it.add_checksum;
                    held_kind = it.reply_kind;
                    push_tx(it.cmd_code);
                    if (it.send_complement)
                        push_tx(8'hFF - it.cmd_code);
                    if (cnt > 0)
                    begin
                        model_phase = sbh_pkg::PH_WAIT_FIRST;
                        wait_ticks = '0;
                    end
                    else
                        enter_reply_wait();
                end
            end
            sbh_pkg::REQ_TICK:
            begin
                if (model_phase != sbh_pkg::PH_IDLE)
                begin
                    if ({1'b0, wait_ticks} + 17'd1 > {1'b0, limit_ticks})
                        finish_txn(sbh_pkg::ST_TIMEOUT, 32'd0);
                    else
                        wait_ticks = wait_ticks + 16'd1;
                end
            end
            sbh_pkg::REQ_BYTE:
            begin
                if (model_phase == sbh_pkg::PH_WAIT_FIRST)
                begin
                    if (it.rx_data != sbh_pkg::ACK_BYTE)
                        finish_txn(sbh_pkg::ST_NACK, 32'd0);
                    else
                    begin
                        // send argument bytes, most significant first
                        x = 8'd0;
                        for (int i = 0; i < held_count; i++)
                        begin
                            sh = int'(held_count) - 1 - i;
                            b = (sh >= 4) ? 8'd0 : held_word[sh*8 +: 8];
                            x = x ^ b;
                            push_tx(b);
                        end
                        if (held_csum)
                            push_tx(x);
                        enter_reply_wait();
                    end
                end
                else if (model_phase == sbh_pkg::PH_WAIT_REPLY)
                begin
                    ndata = (held_kind == sbh_pkg::RK_ACK_ONLY) ? 0 :
                            ((held_kind == sbh_pkg::RK_ONE_BYTE) ? 1 : 4);
                    if (reply_pos == 3'd0)
                    begin
                        if (it.rx_data != sbh_pkg::ACK_BYTE)
                            finish_txn(sbh_pkg::ST_NACK, 32'd0);
                        else if (ndata == 0)
                            finish_txn(sbh_pkg::ST_OK, 32'd0);
                        else
                            reply_pos = 3'd1;
                    end
                    else if (reply_pos <= ndata)
                    begin
                        reply_acc = {reply_acc[23:0], it.rx_data};
                        reply_pos = reply_pos + 3'd1;
                    end
                    else if (it.rx_data != sbh_pkg::ACK_BYTE)
                        finish_txn(sbh_pkg::ST_NACK, 32'd0);
                    else
                        finish_txn(sbh_pkg::ST_OK, reply_acc);
                end
            end
            default: ;
        endcase
        if (step_words.size() > 0)
            step_words[step_words.size() - 1].last = 1'b1;
        foreach (step_words[i])
            due_words.push_back(step_words[i]);
    endtask

    // Item builders

    function automatic sbh_pkg::item_t junk_item(input logic [1:0] req);
        sbh_pkg::item_t it;
        it.req_type = req;
        it.cmd_code = 8'($urandom);
        it.send_complement = 1'($urandom);
        it.arg_count = 3'($urandom);
        it.arg_word = $urandom;
        it.add_checksum = 1'($urandom);
        it.reply_kind = 2'($urandom);
        it.rx_data = 8'($urandom);
        return it;
    endfunction

    task automatic add_item(input sbh_pkg::item_t it);
        item_q.push_back(it);
        items_open++;
        items_made++;
    endtask

    task automatic add_start(input logic [7:0] cmd, input logic comp, input logic [2:0] cnt,
                             input logic [31:0] word, input logic csum, input logic [1:0] kind);
        sbh_pkg::item_t it;
        it = junk_item(sbh_pkg::REQ_START);
        it.cmd_code = cmd;
        it.send_complement = comp;
        it.arg_count = cnt;
        it.arg_word = word;
        it.add_checksum = csum;
        it.reply_kind = kind;
        add_item(it);
    endtask

    task automatic add_byte(input logic [7:0] rx);
        sbh_pkg::item_t it;
        it = junk_item(sbh_pkg::REQ_BYTE);
        it.rx_data = rx;
        add_item(it);
    endtask

    task automatic add_tick();
        add_item(junk_item(sbh_pkg::REQ_TICK));
    endtask

    task automatic add_some_ticks();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) add_tick();
    endtask

    // An ACK position: mostly a real ACK, now and then a wrong byte that ends the run
    task automatic add_ack_slot(output bit broke);
        logic [7:0] b;
        broke = ($urandom_range(0, 11) == 0);
        b = 8'($urandom);
        if (b == sbh_pkg::ACK_BYTE)
            b = 8'h00;
        add_byte(broke ? b : sbh_pkg::ACK_BYTE);
    endtask

    task automatic gen_txn();
        logic [2:0] cnt;
        logic [1:0] kind;
        int ndata;
        bit broke;
        cnt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        kind = 2'($urandom_range(0, 3));
        add_start(8'($urandom), 1'($urandom), cnt, $urandom, 1'($urandom), kind);
        if ($urandom_range(0, 9) == 0)
            add_item(junk_item(sbh_pkg::REQ_START));
        if (cnt != 3'd0)
        begin
            add_some_ticks();
            add_ack_slot(broke);
            if (broke)
                return;
        end
        add_some_ticks();
        add_ack_slot(broke);
        if (broke)
            return;
        ndata = (kind == sbh_pkg::RK_ACK_ONLY) ? 0 : ((kind == sbh_pkg::RK_ONE_BYTE) ? 1 : 4);
        if (ndata > 0)
        begin
            repeat (ndata)
            begin
                add_some_ticks();
                add_byte(8'($urandom));
            end
            add_some_ticks();
            add_ack_slot(broke);
            if (broke)
                return;
        end
        // stray traffic while idle
        if ($urandom_range(0, 9) == 0)
            add_byte(8'($urandom));
        if ($urandom_range(0, 9) == 0)
            add_tick();
        if ($urandom_range(0, 19) == 0)
            add_item(junk_item(REQ_UNUSED));
    endtask

    task automatic gen_random(input int n);
        int target;
        target = items_made + n;
        while (items_made < target)
            gen_txn();
    endtask

    task automatic wait_quiet();
        while (items_open != 0 || due_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register access

    task automatic check_timeout_reg(input logic [15:0] want);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_TIMEOUT;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata[15:0] !== want)
            report_error($sformatf("timeout_ticks read %0d, want %0d", prdata[15:0], want));
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_timeout(input logic [15:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_TIMEOUT;
        pwdata <= {16'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        limit_ticks = v;
        check_timeout_reg(v);
    endtask

    // Sender: present queued words in bursts, predict on acceptance
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_words(cur_item);
                items_open--;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (item_q.size() > 0)
                begin
                    cur_item = item_q.pop_front();
                    s_tdata <= {1'b0, cur_item.rx_data, cur_item.reply_kind, cur_item.add_checksum,
                                cur_item.arg_word, cur_item.arg_count, cur_item.send_complement,
                                cur_item.cmd_code};
                    s_tuser <= cur_item.req_type;
                    s_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 15);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: runs of ready and stall, plus one long hold on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (long_hold_req && !long_hold_done)
        begin
            hold_left = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
            m_tready <= 1'b0;
        end
        else
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(1, 6);
                run_ready = ($urandom_range(0, 99) >= rx_stall_pct);
            end
            run_left--;
            m_tready <= run_ready;
        end
    end

    // Check each accepted result word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_words.size() == 0)
                report_error($sformatf("unexpected word kind=%b tdata=%h last=%b",
                                       m_tuser, m_tdata, m_tlast));
            else
            begin
                seen_word = due_words.pop_front();
                if (m_tuser !== seen_word.kind)
                    report_error($sformatf("out_kind %b, want %b", m_tuser, seen_word.kind));
                if (m_tdata[7:0] !== seen_word.tx)
                    report_error($sformatf("tx_data %h, want %h", m_tdata[7:0], seen_word.tx));
                if (m_tdata[9:8] !== seen_word.st)
                    report_error($sformatf("status %0d, want %0d", m_tdata[9:8], seen_word.st));
                if (m_tdata[41:10] !== seen_word.data)
                    report_error($sformatf("reply_data %h, want %h", m_tdata[41:10],
                                           seen_word.data));
                if (m_tlast !== seen_word.last)
                    report_error($sformatf("last %b, want %b", m_tlast, seen_word.last));
            end
        end
    end

    // Watchdog on cycles with no traffic at all
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        check_timeout_reg(sbh_pkg::TIMEOUT_RESET);

        // Drops while idle and the unused request code
        add_tick();
        add_byte(sbh_pkg::ACK_BYTE);
        add_item(junk_item(REQ_UNUSED));
        // Widest transaction, with a start dropped while busy
        add_start(8'h00, 1'b1, 3'd4, 32'hFFFF_FFFF, 1'b1, 2'd2);
        add_start(8'hFF, 1'b1, 3'd1, 32'h0, 1'b0, sbh_pkg::RK_ACK_ONLY);
        add_byte(sbh_pkg::ACK_BYTE);
        add_tick();
        add_byte(sbh_pkg::ACK_BYTE);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'hA5);
        add_byte(8'h5A);
        add_byte(sbh_pkg::ACK_BYTE);
        // Saturated argument count, reply kind three, bad closing ACK
        add_start(8'hFF, 1'b0, 3'd7, 32'h1234_5678, 1'b0, 2'd3);
        add_byte(sbh_pkg::ACK_BYTE);
        add_byte(sbh_pkg::ACK_BYTE);
        repeat (4) add_byte(8'($urandom));
        add_byte(8'h1F);
        // No arguments, ACK-only reply
        add_start(8'h5A, 1'b1, 3'd0, 32'h0, 1'b1, sbh_pkg::RK_ACK_ONLY);
        add_byte(sbh_pkg::ACK_BYTE);
        // Wrong byte where the first ACK belongs
        add_start(8'h31, 1'b0, 3'd1, 32'h0000_00AB, 1'b1, sbh_pkg::RK_ONE_BYTE);
        add_byte(8'h1F);
        wait_quiet();

        // Limit of one tick: timeouts on a second tick
        write_timeout(16'd1);
        rx_stall_pct = 30;
        add_start(8'h11, 1'b0, 3'd0, 32'h0, 1'b0, sbh_pkg::RK_ONE_BYTE);
        add_tick();
        add_tick();
        gen_random(40);
        wait_quiet();

        // Widest limit, with a long receiver hold while words keep coming
        write_timeout(16'hFFFF);
        rx_stall_pct = 20;
        gen_random(45);
        long_hold_req = 1'b1;
        wait_quiet();

        write_timeout(16'd3);
        rx_stall_pct = 60;
        gen_random(45);
        wait_quiet();

        write_timeout(sbh_pkg::TIMEOUT_RESET);
        rx_stall_pct = 0;
        gen_random(40);
        wait_quiet();

        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/sbh_pkg.sv
hw/rtl/sbh_ctrl.sv
hw/rtl/sbh_batch.sv
hw/rtl/serial_bootloader_host_transaction.sv
sim/tb_serial_bootloader_host_transaction.sv
